// File: rtl/spsg_pkg.sv
// ----------------------------------------------------------------------------
// spsg_pkg
// Types and constants shared by the stereo tone and noise generator.
// ----------------------------------------------------------------------------
package spsg_pkg;

  // Item codes on the input channel; the remaining code is a no-op
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LEFT  = 2'd1,
    OP_RIGHT = 2'd2
  } spsg_op_e;

  localparam int unsigned PeriodW = 10;
  localparam int unsigned AttW    = 4;
  localparam int unsigned LfsrW   = 15;
  localparam int unsigned NumTone = 3;
  localparam int unsigned NumChan = 4;

  localparam logic [AttW-1:0]    Silent    = 4'd15;
  localparam logic [LfsrW-1:0]   LfsrSeed  = 15'h4000;
  localparam logic [PeriodW-1:0] NoiseRate0 = 10'h010;
  localparam logic [PeriodW-1:0] NoiseRate1 = 10'h020;
  localparam logic [PeriodW-1:0] NoiseRate2 = 10'h040;

  // Latched channel codes with a special meaning on the right port
  localparam logic [1:0] ChNoisePitch = 2'd2;
  localparam logic [1:0] ChNoiseCtrl  = 2'd3;

  // Noise rate select codes
  localparam logic [1:0] RateSel0      = 2'd0;
  localparam logic [1:0] RateSel1      = 2'd1;
  localparam logic [1:0] RateSel2      = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } spsg_in_t;

  typedef struct packed {
    logic [AttW-1:0] tone_a_left;
    logic [AttW-1:0] tone_b_left;
    logic [AttW-1:0] tone_c_left;
    logic [AttW-1:0] noise_left;
    logic [AttW-1:0] tone_a_right;
    logic [AttW-1:0] tone_b_right;
    logic [AttW-1:0] tone_c_right;
    logic [AttW-1:0] noise_right;
  } spsg_out_t;

  // Noise settings handed from the port registers to the noise channel
  typedef struct packed {
    logic [PeriodW-1:0] period;
    logic [1:0]         rate_sel;
    logic               white;
    logic               reload;
  } spsg_noise_cfg_t;

endpackage

// File: rtl/spsg_regs.sv
// ----------------------------------------------------------------------------
// spsg_regs
// Port write decoder: latch, tone periods, attenuations and noise settings.
// ----------------------------------------------------------------------------
module spsg_regs (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        wr_left_i,
  input  logic                                        wr_right_i,
  input  logic [7:0]                                  wr_byte_i,
  output logic [spsg_pkg::NumTone-1:0][spsg_pkg::PeriodW-1:0] tone_period_o,
  output logic [spsg_pkg::NumChan-1:0][spsg_pkg::AttW-1:0]    left_att_o,
  output logic [spsg_pkg::NumChan-1:0][spsg_pkg::AttW-1:0]    right_att_o,
  output spsg_pkg::spsg_noise_cfg_t                           noise_cfg_o
);
  import spsg_pkg::*;

  // Latch byte sets the low four bits, data byte the upper six
  function automatic logic [PeriodW-1:0] merge_period(logic [PeriodW-1:0] p,
                                                      logic [7:0] b);
    merge_period = b[7] ? {p[PeriodW-1:4], b[3:0]} : {b[5:0], p[3:0]};
  endfunction

  logic                               is_vol_q, is_vol_d;
  logic [1:0]                         chan_q, chan_d;
  logic [NumTone-1:0][PeriodW-1:0]    tone_period_q, tone_period_d;
  logic [NumChan-1:0][AttW-1:0]       left_att_q, left_att_d;
  logic [NumChan-1:0][AttW-1:0]       right_att_q, right_att_d;
  logic [PeriodW-1:0]                 noise_period_q, noise_period_d;
  logic [1:0]                         rate_sel_q, rate_sel_d;
  logic                               white_q, white_d;
  logic                               reload;
  logic                               any_wr;
  logic                               is_latch;

  assign any_wr   = wr_left_i | wr_right_i;
  assign is_latch = wr_byte_i[7];

  always_comb begin
    is_vol_d       = is_vol_q;
    chan_d         = chan_q;
    tone_period_d  = tone_period_q;
    left_att_d     = left_att_q;
    right_att_d    = right_att_q;
    noise_period_d = noise_period_q;
    rate_sel_d     = rate_sel_q;
    white_d        = white_q;
    reload         = 1'b0;

    if (any_wr && is_latch) begin
      is_vol_d = wr_byte_i[4];
      chan_d   = wr_byte_i[6:5];
    end

    if (wr_left_i) begin
      if (is_latch && wr_byte_i[4]) begin
        left_att_d[wr_byte_i[6:5]] = wr_byte_i[3:0];
      end
      if (!is_vol_d && chan_d != ChNoiseCtrl) begin
        tone_period_d[chan_d] = merge_period(tone_period_q[chan_d], wr_byte_i);
      end
    end

    if (wr_right_i) begin
      if (is_latch && wr_byte_i[4]) begin
        right_att_d[wr_byte_i[6:5]] = wr_byte_i[3:0];
      end
      if (!is_vol_d) begin
        if (chan_d == ChNoisePitch) begin
          noise_period_d = merge_period(noise_period_q, wr_byte_i);
        end else if (chan_d == ChNoiseCtrl && is_latch) begin
          rate_sel_d = wr_byte_i[1:0];
          white_d    = wr_byte_i[2];
          reload     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_vol_q       <= 1'b0;
      chan_q         <= '0;
      tone_period_q  <= '0;
      left_att_q     <= '0;
      right_att_q    <= '0;
      noise_period_q <= '0;
      rate_sel_q     <= '0;
      white_q        <= 1'b0;
    end else begin
      is_vol_q       <= is_vol_d;
      chan_q         <= chan_d;
      tone_period_q  <= tone_period_d;
      left_att_q     <= left_att_d;
      right_att_q    <= right_att_d;
      noise_period_q <= noise_period_d;
      rate_sel_q     <= rate_sel_d;
      white_q        <= white_d;
    end
  end

  assign tone_period_o      = tone_period_q;
  assign left_att_o         = left_att_q;
  assign right_att_o        = right_att_q;
  assign noise_cfg_o.period   = noise_period_q;
  assign noise_cfg_o.rate_sel = rate_sel_q;
  assign noise_cfg_o.white    = white_q;
  assign noise_cfg_o.reload   = reload;

endmodule

// File: rtl/spsg_tone.sv
// ----------------------------------------------------------------------------
// spsg_tone
// One square-wave tone channel: countdown and output level.
// ----------------------------------------------------------------------------
module spsg_tone (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_i,
  input  logic [spsg_pkg::PeriodW-1:0]  period_i,
  output logic                          level_next_o
);
  import spsg_pkg::*;

  logic [PeriodW-1:0] count_q, count_d;
  logic               level_q, level_d;
  logic               expired;

  assign expired = (count_q == '0);

  always_comb begin
    count_d = count_q;
    level_d = level_q;
    if (tick_i) begin
      // reload and toggle on expiry, otherwise count down
      if (expired) begin
        count_d = period_i;
        level_d = ~level_q;
      end else begin
        count_d = count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      level_q <= 1'b0;
    end else begin
      count_q <= count_d;
      level_q <= level_d;
    end
  end

  // Level as it stands after the current tick
  assign level_next_o = expired ? ~level_q : level_q;

endmodule

// File: rtl/spsg_noise.sv
// ----------------------------------------------------------------------------
// spsg_noise
// Noise channel: rate countdown, half-phase divider and 15-bit LFSR.
// ----------------------------------------------------------------------------
module spsg_noise (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       tick_i,
  input  spsg_pkg::spsg_noise_cfg_t  cfg_i,
  output logic                       level_next_o
);
  import spsg_pkg::*;

  logic [PeriodW-1:0] count_q, count_d;
  logic               phase_q, phase_d;
  logic               level_q, level_d;
  logic [LfsrW-1:0]   lfsr_q, lfsr_d;
  logic [PeriodW-1:0] reload_val;
  logic               expired;
  logic               shift;
  logic               feedback;

  assign expired  = (count_q == '0);
  assign shift    = expired & ~phase_q;
  assign feedback = lfsr_q[0] ^ (lfsr_q[2] & cfg_i.white);

  always_comb begin
    case (cfg_i.rate_sel)
      RateSel0: reload_val = NoiseRate0;
      RateSel1: reload_val = NoiseRate1;
      RateSel2: reload_val = NoiseRate2;
      default:  reload_val = cfg_i.period;
    endcase
  end

  always_comb begin
    count_d = count_q;
    phase_d = phase_q;
    level_d = level_q;
    lfsr_d  = lfsr_q;
    if (cfg_i.reload) begin
      lfsr_d = LfsrSeed;
    end else if (tick_i) begin
      if (expired) begin
        count_d = reload_val;
        phase_d = ~phase_q;
        // shift only on the rising half-phase
        if (shift) begin
          level_d = ~lfsr_q[0];
          lfsr_d  = {feedback, lfsr_q[LfsrW-1:1]};
        end
      end else begin
        count_d = count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      phase_q <= 1'b0;
      level_q <= 1'b0;
      lfsr_q  <= '0;
    end else begin
      count_q <= count_d;
      phase_q <= phase_d;
      level_q <= level_d;
      lfsr_q  <= lfsr_d;
    end
  end

  assign level_next_o = shift ? ~lfsr_q[0] : level_q;

endmodule

// File: rtl/stereo_psg_tone_noise.sv
// ----------------------------------------------------------------------------
// stereo_psg_tone_noise
// Stereo sound generator: three square-wave tones and one noise channel,
// each with its own left and right attenuation, fed by two write ports.
// ----------------------------------------------------------------------------
//
//   channel | handshake                | word       | meaning
//   --------+--------------------------+------------+--------------------------
//   in      | in_valid_i / in_ready_o  | spsg_in_t  | tick, left or right write
//   out     | out_valid_o / out_ready_i| spsg_out_t | eight attenuations a tick
//
// A word is taken into the input register, then processed: a tick into
// the result register, a write into the port registers.
// One word a cycle is sustained; the result register bounds throughput only
// when it holds an untaken result and the next word is a tick.
// Port writes never wait on the output side and produce no result.
// Reset clears every channel counter, level, period, attenuation and the LFSR.
// ----------------------------------------------------------------------------
module stereo_psg_tone_noise (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  spsg_pkg::spsg_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output spsg_pkg::spsg_out_t  out_data_o
);
  import spsg_pkg::*;

  // Input register
  logic      in_valid_q, in_valid_d;
  spsg_in_t  in_q;

  // Result register
  logic      out_valid_q, out_valid_d;
  spsg_out_t out_q, out_d;

  logic      out_free;
  logic      is_tick;
  logic      advance;
  logic      tick;
  logic      wr_left;
  logic      wr_right;

  logic [NumTone-1:0][PeriodW-1:0] tone_period;
  logic [NumChan-1:0][AttW-1:0]    left_att;
  logic [NumChan-1:0][AttW-1:0]    right_att;
  spsg_noise_cfg_t                 noise_cfg;
  logic [NumChan-1:0]              level_next;

  // A tick needs room in the result register; writes always move on
  assign out_free = ~out_valid_q | out_ready_i;
  assign is_tick  = (in_q.opcode == OP_TICK);
  assign advance  = in_valid_q & (~is_tick | out_free);

  assign tick     = advance & is_tick;
  assign wr_left  = advance & (in_q.opcode == OP_LEFT);
  assign wr_right = advance & (in_q.opcode == OP_RIGHT);

  // Take a new word when none is held or the held one leaves this cycle
  assign in_ready_o = ~in_valid_q | advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Payload holds while stalled; no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  spsg_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_left_i     (wr_left),
    .wr_right_i    (wr_right),
    .wr_byte_i     (in_q.data_byte),
    .tone_period_o (tone_period),
    .left_att_o    (left_att),
    .right_att_o   (right_att),
    .noise_cfg_o   (noise_cfg)
  );

  for (genvar g = 0; g < NumTone; g++) begin : g_tone
    spsg_tone u_tone (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .tick_i       (tick),
      .period_i     (tone_period[g]),
      .level_next_o (level_next[g])
    );
  end

  spsg_noise u_noise (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .cfg_i        (noise_cfg),
    .level_next_o (level_next[NumChan-1])
  );

  // Gate each attenuation by the level after this tick; low reads as silent
  always_comb begin
    out_d.tone_a_left  = level_next[0] ? left_att[0]  : Silent;
    out_d.tone_b_left  = level_next[1] ? left_att[1]  : Silent;
    out_d.tone_c_left  = level_next[2] ? left_att[2]  : Silent;
    out_d.noise_left   = level_next[3] ? left_att[3]  : Silent;
    out_d.tone_a_right = level_next[0] ? right_att[0] : Silent;
    out_d.tone_b_right = level_next[1] ? right_att[1] : Silent;
    out_d.tone_c_right = level_next[2] ? right_att[2] : Silent;
    out_d.noise_right  = level_next[3] ? right_att[3] : Silent;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (tick) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/spsg_chk.sv
// ----------------------------------------------------------------------------
// spsg_chk
// Port-level checks for the stereo tone and noise generator.
// ----------------------------------------------------------------------------
module spsg_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input spsg_pkg::spsg_in_t   in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input spsg_pkg::spsg_out_t  out_data_o
);
  import spsg_pkg::*;

  // Hold a stalled result word unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed or dropped");

  // Input side never stalls while nothing waits at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // A fresh result follows a tick accepted into the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && in_ready_o && in_data_i.opcode == OP_TICK, 2))
    else $error("result word without a matching tick");

  // No result is shown while reset is held
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind stereo_psg_tone_noise spsg_chk u_spsg_chk (.*);

// File: tb/tb_stereo_psg_tone_noise.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_psg_tone_noise
// Self-checking bench for the stereo tone and noise generator. It drives
// ticks, left and right port bytes and unused codes through the valid/ready
// input, and mirrors the tone, noise and attenuation state in a scoreboard.
// Each result word is compared field by field with the predicted one.
// Random idling hits both sides, and one long output stall backs up the pipe.
// ----------------------------------------------------------------------------
module tb_stereo_psg_tone_noise;
  import spsg_pkg::*;

  // Code left free by the package: the block must swallow it silently
  localparam logic [1:0] OpUnused = 2'd3;

  // Mirror of the generator plus the queue of attenuation words still owed
  class psg_scoreboard;
    bit               lat_vol;
    bit [1:0]         lat_ch;
    bit [PeriodW-1:0] tone_per [NumTone];
    bit [PeriodW-1:0] tone_cnt [NumTone];
    bit               tone_lvl [NumTone];
    bit [AttW-1:0]    att_l [NumChan];
    bit [AttW-1:0]    att_r [NumChan];
    bit [PeriodW-1:0] nz_per;
    bit [PeriodW-1:0] nz_cnt;
    bit [1:0]         nz_rate;
    bit               nz_white;
    bit [LfsrW-1:0]   lfsr;
    bit               nz_phase;
    bit               nz_lvl;
    spsg_out_t        owed_q [$];
    int unsigned      mismatches, ticks, lefts, rights, unused, checked;

    // Latch bytes replace the low nibble, data bytes the upper six bits
    function automatic bit [PeriodW-1:0] with_pitch(bit [PeriodW-1:0] p, bit [7:0] b);
      return b[7] ? {p[PeriodW-1:4], b[3:0]} : {b[5:0], p[3:0]};
    endfunction

    function void port_write(bit right, bit [7:0] b);
      if (b[7]) begin
        lat_vol = b[4];
        lat_ch  = b[6:5];
        if (lat_vol) begin
          if (right) att_r[lat_ch] = b[3:0];
          else att_l[lat_ch] = b[3:0];
        end
      end
      if (lat_vol) return;
      if (!right) begin
        if (lat_ch < NumTone) tone_per[lat_ch] = with_pitch(tone_per[lat_ch], b);
      end else if (lat_ch == ChNoisePitch) begin
        nz_per = with_pitch(nz_per, b);
      end else if (lat_ch == ChNoiseCtrl && b[7]) begin
        nz_rate  = b[1:0];
        nz_white = b[2];
        lfsr     = LfsrSeed;
      end
    endfunction

    function void clock_tick();
      spsg_out_t r;
      bit        fb;
      for (int i = 0; i < NumTone; i++) begin
        if (tone_cnt[i] == '0) begin
          tone_cnt[i] = tone_per[i];
          tone_lvl[i] = ~tone_lvl[i];
        end else begin
          tone_cnt[i] = tone_cnt[i] - 1'b1;
        end
      end
      if (nz_cnt != '0) begin
        nz_cnt = nz_cnt - 1'b1;
      end else begin
        case (nz_rate)
          RateSel0: nz_cnt = NoiseRate0;
          RateSel1: nz_cnt = NoiseRate1;
          RateSel2: nz_cnt = NoiseRate2;
          default:  nz_cnt = nz_per;
        endcase
        nz_phase = ~nz_phase;
        if (nz_phase) begin
          fb     = lfsr[0] ^ (lfsr[2] & nz_white);
          nz_lvl = ~lfsr[0];
          lfsr   = {fb, lfsr[LfsrW-1:1]};
        end
      end
      r.tone_a_left  = tone_lvl[0] ? att_l[0] : Silent;
      r.tone_b_left  = tone_lvl[1] ? att_l[1] : Silent;
      r.tone_c_left  = tone_lvl[2] ? att_l[2] : Silent;
      r.noise_left   = nz_lvl      ? att_l[3] : Silent;
      r.tone_a_right = tone_lvl[0] ? att_r[0] : Silent;
      r.tone_b_right = tone_lvl[1] ? att_r[1] : Silent;
      r.tone_c_right = tone_lvl[2] ? att_r[2] : Silent;
      r.noise_right  = nz_lvl      ? att_r[3] : Silent;
      owed_q.push_back(r);
    endfunction

    // Note one accepted input word
    function void note_word(spsg_in_t w);
      case (w.opcode)
        OP_TICK:  begin ticks++;  clock_tick(); end
        OP_LEFT:  begin lefts++;  port_write(1'b0, w.data_byte); end
        OP_RIGHT: begin rights++; port_write(1'b1, w.data_byte); end
        default:  unused++;
      endcase
    endfunction

    function void cmp_att(string name, logic [AttW-1:0] want, logic [AttW-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Check one accepted result word against the oldest owed one
    function void check_result(spsg_out_t got);
      spsg_out_t want;
      if (owed_q.size() == 0) begin
        $error("result word with no tick outstanding: %h", got);
        mismatches++;
        return;
      end
      want = owed_q.pop_front();
      checked++;
      cmp_att("tone_a_left",  want.tone_a_left,  got.tone_a_left);
      cmp_att("tone_b_left",  want.tone_b_left,  got.tone_b_left);
      cmp_att("tone_c_left",  want.tone_c_left,  got.tone_c_left);
      cmp_att("noise_left",   want.noise_left,   got.noise_left);
      cmp_att("tone_a_right", want.tone_a_right, got.tone_a_right);
      cmp_att("tone_b_right", want.tone_b_right, got.tone_b_right);
      cmp_att("tone_c_right", want.tone_c_right, got.tone_c_right);
      cmp_att("noise_right",  want.noise_right,  got.noise_right);
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  spsg_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  spsg_out_t out_data;

  psg_scoreboard sb = new();
  bit            calm;       // set for the last stretch: no idling on either side
  bit            held_once;

  stereo_psg_tone_noise dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #5 clk_i = ~clk_i;

  // Sample both handshakes with pre-edge values; inputs are noted before the
  // result check so a tick is always owed before its word can come back.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.note_word(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // Offer one word and hold it until taken; sometimes drop valid first for
  // a short burst. Valid is left high on return so back-to-back words flow.
  task automatic put_word(logic [1:0] op, logic [7:0] b);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, data_byte: b};
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic put_ticks(int unsigned n);
    repeat (n) put_word(OP_TICK, 8'h00);
  endtask

  // Receiver: short random stalls, plus one long hold-off that lets ticks
  // pile up until the block refuses input.
  initial begin
    out_ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!held_once && sb.checked >= 200) begin
        held_once = 1'b1;
        out_ready <= 1'b0;
        repeat (80) @(posedge clk_i);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned pick;
    logic [1:0]  ch;
    logic        side;

    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: first tick from reset, every attenuation extreme,
    // period extremes, ignored data after a volume latch, pitch to channels
    // that have no period, noise control with LFSR reload, and the unused code.
    put_ticks(1);
    put_word(OP_LEFT,  8'h9F);   // tone A left silent
    put_word(OP_LEFT,  8'hB0);   // tone B left loudest
    put_word(OP_LEFT,  8'hD5);
    put_word(OP_LEFT,  8'hF7);   // noise left
    put_word(OP_RIGHT, 8'h90);
    put_word(OP_RIGHT, 8'hBA);
    put_word(OP_RIGHT, 8'hDF);
    put_word(OP_RIGHT, 8'hF3);
    put_word(OP_LEFT,  8'h8F);   // tone A pitch low nibble
    put_word(OP_LEFT,  8'h3F);   // top period bits all set
    put_word(OP_LEFT,  8'h40);   // clear them again, bit 6 ignored
    put_word(OP_LEFT,  8'h7F);   // data with tone latch still active
    put_word(OP_LEFT,  8'hD2);   // volume latch, then data to be ignored
    put_word(OP_LEFT,  8'h7F);
    put_word(OP_RIGHT, 8'hC3);   // noise pitch
    put_word(OP_RIGHT, 8'h00);
    put_word(OP_RIGHT, 8'hEF);   // noise control: own rate, white, reload
    put_word(OP_RIGHT, 8'h85);   // right pitch to a tone: no period there
    put_word(OP_RIGHT, 8'h2A);
    put_word(OP_LEFT,  8'hE2);   // left pitch to noise: no period there
    put_word(OP_LEFT,  8'h11);
    put_word(OpUnused, 8'hFF);
    put_ticks(3);

    // Random phrases: mostly well-formed latch/data programs with random
    // content between bursts of ticks, some loose bytes and unused codes.
    sent = 0;
    while (sent < 1600) begin
      calm = (sent >= 1400);
      pick = $urandom_range(0, 99);
      ch   = 2'($urandom_range(0, 2));
      side = 1'($urandom_range(0, 1));
      if (pick < 45) begin
        pick = $urandom_range(1, 8);
        put_ticks(pick);
        sent += pick;
      end else if (pick < 60) begin
        put_word(OP_LEFT, {1'b1, ch, 1'b0, 4'($urandom)});
        sent++;
        if ($urandom_range(0, 3) != 0) begin
          // keep most periods short so the tones toggle often
          put_word(OP_LEFT, {1'b0, 1'($urandom), ($urandom_range(0, 9) == 0) ?
                             6'($urandom) : 6'($urandom_range(0, 2))});
          sent++;
        end
      end else if (pick < 70) begin
        put_word(side ? OP_RIGHT : OP_LEFT, {1'b1, 2'($urandom), 1'b1, 4'($urandom)});
        sent++;
      end else if (pick < 78) begin
        put_word(OP_RIGHT, {3'b110, 1'b0, 4'($urandom)});
        put_word(OP_RIGHT, {1'b0, 1'($urandom), 6'($urandom_range(0, 3))});
        sent += 2;
      end else if (pick < 85) begin
        put_word(OP_RIGHT, {3'b111, 1'b0, 4'($urandom)});
        sent++;
      end else if (pick < 95) begin
        put_word(side ? OP_RIGHT : OP_LEFT, 8'($urandom));
        sent++;
      end else begin
        put_word(OpUnused, 8'($urandom));
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed word, then idle on to catch strays
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d ticks, %0d left and %0d right port writes, %0d unused-code words.",
             sb.ticks, sb.lefts, sb.rights, sb.unused);
    $display("Checked %0d attenuation words, with one long output hold-off.", sb.checked);
    if (sb.mismatches == 0) begin
      $display("tb_stereo_psg_tone_noise passed");
    end else begin
      $display("tb_stereo_psg_tone_noise failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb_stereo_psg_tone_noise failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/spsg_pkg.sv
rtl/spsg_regs.sv
rtl/spsg_tone.sv
rtl/spsg_noise.sv
rtl/stereo_psg_tone_noise.sv
rtl/spsg_chk.sv
tb/tb_stereo_psg_tone_noise.sv
